@@ design/tcp_flow_table_lookup_insert_assert.svh @@
// ----------------------------------------------------------------------------
// TCP flow table assertion macros
// Shared property forms for the flow table checkers. Each macro expects clk
// and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef TCP_FLOW_TABLE_LOOKUP_INSERT_ASSERT_SVH
`define TCP_FLOW_TABLE_LOOKUP_INSERT_ASSERT_SVH

// Same-cycle implication
`define TFTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TFTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tftl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP flow table package
// Sizes, entry layout and the command/status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tftl_pkg;

    localparam int TABLE_ENTRIES = 512;
    localparam int COUNT_BITS    = 32;
    localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
    localparam int PORT_SHIFT    = 16;

    // Port widths fixed by the interface
    localparam int ADDR_W       = 32;
    localparam int PORT_W       = 16;
    localparam int HASH_W       = 32;
    localparam int FLOW_SLOT_W  = 9;
    localparam int PKT_COUNT_W  = 32;

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
    } flow_key_t;

    typedef struct packed {
        logic      valid;
        flow_key_t key;
        count_t    count;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;     // write an empty entry at the current slot
        logic load_key;     // capture the incoming tuple, set home slot
        logic slot_step;    // advance slot with wraparound
        logic probe_step;   // count one more probe
        logic commit;       // write entry back, load result
        logic report_full;  // load a table-full result
    } tftl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;          // probed entry holds this flow
        logic empty;        // probed entry is free
        logic probe_last;   // every slot has been probed
        logic slot_last;    // slot pointer at the last entry
        logic out_free;     // result register can take a new result
    } tftl_status_t;

endpackage

@@ design/tcp_flow_table_lookup_insert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP flow table lookup and insert
// Hashes a TCP four-tuple, probes a 512-entry table linearly and returns the
// flow's slot and packet count, claiming a free slot for a new flow.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table once to mark every slot free, one
// slot per cycle, with in_ready low. Each packet then probes P slots from its
// home slot, where P is the number of slots probed (1 for a hit or a free
// home slot): every probe is one read of the entry memory and then one
// compare, and the write-back follows, waiting while the previous result is
// still held. A new packet is taken only in the idle state, once the block is
// through with the last one. A full table costs all 512 probes and returns
// table_full with nothing changed. A result waits in the output register, so
// the next packet is taken while it does.
// ----------------------------------------------------------------------------
module tcp_flow_table_lookup_insert (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tftl_pkg::ADDR_W-1:0]       source_address,
    input  logic [tftl_pkg::ADDR_W-1:0]       dest_address,
    input  logic [tftl_pkg::PORT_W-1:0]       source_port,
    input  logic [tftl_pkg::PORT_W-1:0]       dest_port,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tftl_pkg::FLOW_SLOT_W-1:0]  flow_slot,
    output logic                              new_flow,
    output logic                              table_full,
    output logic [tftl_pkg::PKT_COUNT_W-1:0]  packet_count
);

    tftl_pkg::tftl_cmd_t    cmd;
    tftl_pkg::tftl_status_t status;

    // Sequencer
    tftl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table, hash and result register
    tftl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .source_address (source_address),
        .dest_address   (dest_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .flow_slot      (flow_slot),
        .new_flow       (new_flow),
        .table_full     (table_full),
        .packet_count   (packet_count)
    );

endmodule

@@ design/tftl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP flow table controller
// Sequences the clearing sweep after reset and the probe loop for each
// packet: read, check, then update or report a full table.
// ----------------------------------------------------------------------------
module tftl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tftl_pkg::tftl_status_t status,
    output tftl_pkg::tftl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_UPDATE,
        S_FULL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr  = 1'b1;
                cmd.slot_step = 1'b1;
                if (status.slot_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_key = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.hit || status.empty)
                begin
                    state_next = S_UPDATE;
                end
                else if (status.probe_last)
                begin
                    state_next = S_FULL;
                end
                else
                begin
                    cmd.slot_step  = 1'b1;
                    cmd.probe_step = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FULL:
            begin
                if (status.out_free)
                begin
                    cmd.report_full = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/tftl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP flow table datapath
// Key capture and hash, slot pointer and probe counter, the entry memory
// with registered read data, the count update and the result register.
// ----------------------------------------------------------------------------
module tftl_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tftl_pkg::tftl_cmd_t                    cmd,
    output tftl_pkg::tftl_status_t                 status,
    input  logic [tftl_pkg::ADDR_W-1:0]            source_address,
    input  logic [tftl_pkg::ADDR_W-1:0]            dest_address,
    input  logic [tftl_pkg::PORT_W-1:0]            source_port,
    input  logic [tftl_pkg::PORT_W-1:0]            dest_port,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [tftl_pkg::FLOW_SLOT_W-1:0]       flow_slot,
    output logic                                   new_flow,
    output logic                                   table_full,
    output logic [tftl_pkg::PKT_COUNT_W-1:0]       packet_count
);

    localparam tftl_pkg::slot_t  SLOT_LAST = tftl_pkg::SLOT_BITS'(tftl_pkg::TABLE_ENTRIES - 1);
    localparam tftl_pkg::count_t COUNT_MAX = {tftl_pkg::COUNT_BITS{1'b1}};

    tftl_pkg::entry_t mem [tftl_pkg::TABLE_ENTRIES];

    tftl_pkg::flow_key_t key_reg;
    tftl_pkg::entry_t    rd_data_reg;
    tftl_pkg::slot_t     slot_reg;
    tftl_pkg::slot_t     slot_next;
    tftl_pkg::slot_t     probe_cnt_reg;
    tftl_pkg::slot_t     probe_cnt_next;
    tftl_pkg::slot_t     home_slot;
    logic [tftl_pkg::HASH_W-1:0] hash;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [tftl_pkg::FLOW_SLOT_W-1:0]  flow_slot_reg;
    logic                              new_flow_reg;
    logic                              table_full_reg;
    logic [tftl_pkg::PKT_COUNT_W-1:0]  packet_count_reg;

    tftl_pkg::count_t count_new;
    tftl_pkg::entry_t wr_entry;

    // XOR hash of the tuple; table size is a power of two, so modulo is a mask
    assign hash = source_address ^ dest_address
                ^ (tftl_pkg::HASH_W'(source_port) << tftl_pkg::PORT_SHIFT)
                ^ tftl_pkg::HASH_W'(dest_port);
    assign home_slot = tftl_pkg::SLOT_BITS'(hash % tftl_pkg::TABLE_ENTRIES);

    // Probe check on the registered read data
    assign status.empty      = !rd_data_reg.valid;
    assign status.hit        = rd_data_reg.valid && (rd_data_reg.key == key_reg);
    assign status.probe_last = (probe_cnt_reg == SLOT_LAST);
    assign status.slot_last  = (slot_reg == SLOT_LAST);
    assign status.out_free   = !out_valid_reg || out_ready;

    // New flows start at zero and count this packet; counts saturate
    always_comb
    begin
        if (!rd_data_reg.valid)
        begin
            count_new = tftl_pkg::COUNT_BITS'(1);
        end
        else if (rd_data_reg.count == COUNT_MAX)
        begin
            count_new = rd_data_reg.count;
        end
        else
        begin
            count_new = rd_data_reg.count + tftl_pkg::COUNT_BITS'(1);
        end
    end

    assign wr_entry = '{valid: 1'b1, key: key_reg, count: count_new};

    // Slot pointer and probe counter
    always_comb
    begin
        slot_next      = slot_reg;
        probe_cnt_next = probe_cnt_reg;
        if (cmd.load_key)
        begin
            slot_next      = home_slot;
            probe_cnt_next = '0;
        end
        else
        begin
            if (cmd.slot_step)
            begin
                slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
            end
            if (cmd.probe_step)
            begin
                probe_cnt_next = probe_cnt_reg + 1'b1;
            end
        end
    end

    // Result valid
    always_comb
    begin
        if (cmd.commit || cmd.report_full)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            probe_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            probe_cnt_reg <= probe_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Key and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= '{src_addr: source_address, dst_addr: dest_address,
                         src_port: source_port, dst_port: dest_port};
        end
        if (cmd.commit)
        begin
            flow_slot_reg    <= tftl_pkg::FLOW_SLOT_W'(slot_reg);
            new_flow_reg     <= !rd_data_reg.valid;
            table_full_reg   <= 1'b0;
            packet_count_reg <= tftl_pkg::PKT_COUNT_W'(count_new);
        end
        else if (cmd.report_full)
        begin
            flow_slot_reg    <= '0;
            new_flow_reg     <= 1'b0;
            table_full_reg   <= 1'b1;
            packet_count_reg <= '0;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[slot_reg] <= '0;
        end
        else if (cmd.commit)
        begin
            mem[slot_reg] <= wr_entry;
        end
        rd_data_reg <= mem[slot_reg];
    end

    assign out_valid    = out_valid_reg;
    assign flow_slot    = flow_slot_reg;
    assign new_flow     = new_flow_reg;
    assign table_full   = table_full_reg;
    assign packet_count = packet_count_reg;

endmodule

@@ design/tftl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP flow table port checker
// Watches the top-level ports for result consistency and output stability.
// ----------------------------------------------------------------------------
`include "tcp_flow_table_lookup_insert_assert.svh"

module tftl_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [tftl_pkg::ADDR_W-1:0]       source_address,
    input  logic [tftl_pkg::ADDR_W-1:0]       dest_address,
    input  logic [tftl_pkg::PORT_W-1:0]       source_port,
    input  logic [tftl_pkg::PORT_W-1:0]       dest_port,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [tftl_pkg::FLOW_SLOT_W-1:0]  flow_slot,
    input  logic                              new_flow,
    input  logic                              table_full,
    input  logic [tftl_pkg::PKT_COUNT_W-1:0]  packet_count
);

    // A full-table result carries nothing else
    `TFTL_ASSERT_NOW(a_full_clean, out_valid && table_full, flow_slot == '0 && !new_flow && packet_count == '0, "table_full result with nonzero fields")

    // A freshly claimed flow has seen exactly this packet
    `TFTL_ASSERT_NOW(a_new_count_one, out_valid && new_flow, !table_full && packet_count == 1, "new flow count is not one")

    // A hit on a known flow never reports a zero count
    `TFTL_ASSERT_NOW(a_hit_nonzero, out_valid && !new_flow && !table_full, packet_count != '0, "existing flow with zero count")

    // A stalled result holds
    `TFTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(flow_slot) && $stable(packet_count) && $stable(new_flow) && $stable(table_full), "stalled result changed")

endmodule

bind tcp_flow_table_lookup_insert tftl_checker u_tftl_checker (.*);
